FILE: rtl/bidc_pkg.sv
// Types and constants shared by the backlight idle dim controller.
// No dependencies; imported by bidc_step and the top level.
`timescale 1ns / 1ps

package bidc_pkg;

  // Command codes carried in the input tuser field.
  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_WAKE = 2'd1,
    CMD_OFF  = 2'd2
  } cmd_e;

  // Notice codes carried in the output tuser field.
  typedef enum logic [1:0] {
    NOTICE_NONE = 2'd0,
    NOTICE_DIM  = 2'd1,
    NOTICE_WOKE = 2'd2
  } notice_e;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_LVL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_USER_LVL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BL   = 3'd3;

  localparam int unsigned PCT_W   = 7;
  localparam int unsigned BL_W    = 16;
  localparam int unsigned TMO_W   = 16;
  localparam int unsigned DELTA_W = 16;
  localparam int unsigned IDLE_W  = 32;
  localparam int unsigned TMO_MS_W = 26;          // 65535 * 1000 < 2^26
  localparam int unsigned PROD_W  = PCT_W + BL_W; // 100 * 65535 < 2^23

  localparam int unsigned DIM_LEAD_MS = 5000;
  localparam int unsigned MS_PER_S     = 1000;
  localparam logic [PCT_W-1:0] PCT_FULL   = 7'd100;
  localparam logic [BL_W-1:0]  BL_DEFAULT = 16'd255;

  // floor(x / 100) = (x * RECIP) >> RECIP_SHIFT, exact for x < 14.1M
  localparam int unsigned RECIP_W     = 24;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

  typedef struct packed {
    logic [IDLE_W-1:0] idle_ms;
    logic              dimmed;
    logic              off;
    logic [BL_W-1:0]   last_value;
  } state_t;

  // Values derived from configuration, captured with each input word.
  typedef struct packed {
    logic                timer_en;
    logic                dim_ok;
    logic [TMO_MS_W-1:0] timeout_ms;
    logic [TMO_MS_W-1:0] dim_thr;
    logic [PROD_W-1:0]   prod_dim;
    logic [PROD_W-1:0]   prod_user;
  } cfgx_t;

  typedef struct packed {
    logic            apply;
    logic [BL_W-1:0] value;
    logic            dimmed;
    logic            off;
    notice_e         notice;
  } result_t;

endpackage

FILE: rtl/backlight_idle_dim_controller_unit.sv
// Top level of the backlight idle dim controller: stream ports, config registers,
// input and result registers. Depends on bidc_pkg and bidc_step.
`timescale 1ns / 1ps

// Usage
//  Input stream (s_axis_*): one word per event. tuser carries the command
//  (tick, wake, force off), tdata the elapsed milliseconds for a tick.
//  Output stream (m_axis_*): exactly one word per input word, in order,
//  carrying apply, the raw backlight value, dimmed and off flags in tdata and
//  the notice code in tuser.
//  Config channel (cfg_*): register index and data, always ready. Write only
//  while no word is in flight. Percent writes clamp to 100; a max of 0 loads
//  255; unknown indexes are ignored.
//  Path: an accepted input word passes the input register, then the result
//  register, before its result shows on m_axis_tvalid.
//  Throughput: one word per cycle while the sink takes results. The state
//  update (saturating add, two threshold compares and a reciprocal multiply
//  for the /100 scaling) is combinational; the per-percent products and the
//  timeout in ms are formed from the config registers as each word enters.
//  Stall: with the result held, the input register still takes one more
//  word; after that s_axis_tready drops until the sink takes the result.
//  Reset: config returns to 60 s, 30 %, 100 %, 255; idle count, flags and
//  the held backlight value clear; both stages empty.

module backlight_idle_dim_controller_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,   // [15:0] delta_ms
  input  logic [1:0]                    s_axis_tuser,   // [1:0] cmd
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] apply, [16:1] backlight_value, [17] dimmed, [18] screen_off, [23:19] zero
  output logic [23:0]                   m_axis_tdata,
  output logic [1:0]                    m_axis_tuser,   // [1:0] notice
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bidc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);
  import bidc_pkg::*;

  // config registers
  logic [TMO_W-1:0] timeout_q;
  logic [PCT_W-1:0] dim_lvl_q;
  logic [PCT_W-1:0] user_lvl_q;
  logic [BL_W-1:0]  max_bl_q;

  // input register
  logic             s1_valid_q;
  cmd_e             s1_cmd_q;
  logic [DELTA_W-1:0] s1_delta_q;
  cfgx_t            s1_cfgx_q;

  // state and result register
  state_t           state_q, state_d;
  logic             out_valid_q;
  result_t          out_q, res_d;

  logic             s_acc;
  logic             adv;
  logic [PCT_W-1:0] cfg_pct;
  logic [TMO_MS_W-1:0] tmo_ms;
  cfgx_t            cfgx_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_pct = (cfg_data_i[PCT_W-1:0] > PCT_FULL) ? PCT_FULL : cfg_data_i[PCT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q  <= 16'd60;
      dim_lvl_q  <= 7'd30;
      user_lvl_q <= PCT_FULL;
      max_bl_q   <= BL_DEFAULT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TIMEOUT:  timeout_q  <= cfg_data_i[TMO_W-1:0];
        REG_DIM_LVL:  dim_lvl_q  <= cfg_pct;
        REG_USER_LVL: user_lvl_q <= cfg_pct;
        REG_MAX_BL:   max_bl_q   <= (cfg_data_i == '0) ? BL_DEFAULT : cfg_data_i[BL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Config-only terms, captured alongside each input word.
  assign tmo_ms = TMO_MS_W'(timeout_q) * TMO_MS_W'(MS_PER_S);
  always_comb begin
    cfgx_d.timer_en   = (timeout_q != '0);
    cfgx_d.timeout_ms = tmo_ms;
    cfgx_d.dim_ok     = (tmo_ms >= TMO_MS_W'(DIM_LEAD_MS));
    cfgx_d.dim_thr    = tmo_ms - TMO_MS_W'(DIM_LEAD_MS);
    cfgx_d.prod_dim   = PROD_W'(dim_lvl_q) * PROD_W'(max_bl_q);
    cfgx_d.prod_user  = PROD_W'(user_lvl_q) * PROD_W'(max_bl_q);
  end

  // handshake
  assign adv           = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_cmd_q   <= cmd_e'(s_axis_tuser);
      s1_delta_q <= s_axis_tdata;
      s1_cfgx_q  <= cfgx_d;
    end
  end

  bidc_step u_step (
    .state_i  (state_q),
    .cfgx_i   (s1_cfgx_q),
    .cmd_i    (s1_cmd_q),
    .delta_i  (s1_delta_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        state_q <= state_d;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_q.off, out_q.dimmed, out_q.value, out_q.apply};
  assign m_axis_tuser  = out_q.notice;

`ifndef SYNTHESIS
  // a waiting input word is never dropped
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !adv |=> s1_valid_q)
    else $error("input word lost while stalled");

  // a wake leaves the idle count cleared
  a_wake_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (s1_cmd_q == CMD_WAKE) |=> (state_q.idle_ms == '0))
    else $error("idle count not cleared by wake");

  // woke notice only with the screen fully restored
  a_woke: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.notice == NOTICE_WOKE) |-> out_q.apply && !out_q.dimmed && !out_q.off)
    else $error("woke notice with screen still dimmed or off");

  // any write that leaves the screen off writes zero
  a_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.apply && out_q.off |-> (out_q.value == '0))
    else $error("screen off with non-zero backlight write");

  // the held state mirrors the last result issued
  a_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (out_q.value == state_q.last_value) && (out_q.off == state_q.off))
    else $error("result out of step with state");
`endif

endmodule

FILE: rtl/bidc_step.sv
// One step of the idle timer: next state and result from current state and word.
// Depends on bidc_pkg. Purely combinational.
`timescale 1ns / 1ps

module bidc_step (
  input  bidc_pkg::state_t                  state_i,
  input  bidc_pkg::cfgx_t                   cfgx_i,
  input  bidc_pkg::cmd_e                    cmd_i,
  input  logic [bidc_pkg::DELTA_W-1:0]      delta_i,
  output bidc_pkg::state_t                  state_o,
  output bidc_pkg::result_t                 result_o
);
  import bidc_pkg::*;

  logic [IDLE_W:0]                   sum;
  logic [IDLE_W-1:0]                 idle_sat;
  logic [PROD_W-1:0]                 prod_sel;
  logic [PROD_W+RECIP_W-1:0]         recip_prod;
  logic [BL_W-1:0]                   scaled;
  logic                              dim_hit;
  logic                              off_hit;

  assign sum      = {1'b0, state_i.idle_ms} + (IDLE_W+1)'(delta_i);
  assign idle_sat = sum[IDLE_W] ? {IDLE_W{1'b1}} : sum[IDLE_W-1:0];

  // Tick uses the dim level, wake the user level.
  assign prod_sel   = (cmd_i == CMD_WAKE) ? cfgx_i.prod_user : cfgx_i.prod_dim;
  assign recip_prod = (PROD_W+RECIP_W)'(prod_sel) * (PROD_W+RECIP_W)'(RECIP_100);
  assign scaled     = recip_prod[RECIP_SHIFT +: BL_W];

  assign dim_hit = cfgx_i.dim_ok && !state_i.dimmed && !state_i.off &&
                   (idle_sat >= IDLE_W'(cfgx_i.dim_thr));
  assign off_hit = !state_i.off && (idle_sat >= IDLE_W'(cfgx_i.timeout_ms));

  always_comb begin
    state_o         = state_i;
    result_o.apply  = 1'b0;
    result_o.notice = NOTICE_NONE;
    case (cmd_i)
      CMD_TICK: begin
        if (cfgx_i.timer_en) begin
          state_o.idle_ms = idle_sat;
          if (dim_hit) begin
            state_o.dimmed     = 1'b1;
            state_o.last_value = scaled;
            result_o.apply     = 1'b1;
            result_o.notice    = NOTICE_DIM;
          end
          // off overrides the dim write when both land in one tick
          if (off_hit) begin
            state_o.off        = 1'b1;
            state_o.last_value = '0;
            result_o.apply     = 1'b1;
          end
        end
      end
      CMD_WAKE: begin
        state_o.idle_ms = '0;
        if (state_i.dimmed || state_i.off) begin
          state_o.dimmed     = 1'b0;
          state_o.off        = 1'b0;
          state_o.last_value = scaled;
          result_o.apply     = 1'b1;
          result_o.notice    = NOTICE_WOKE;
        end
      end
      CMD_OFF: begin
        state_o.off        = 1'b1;
        state_o.dimmed     = 1'b0;
        state_o.last_value = '0;
        result_o.apply     = 1'b1;
      end
      default: begin
        // unused code: no change
      end
    endcase
    result_o.value  = state_o.last_value;
    result_o.dimmed = state_o.dimmed;
    result_o.off    = state_o.off;
  end

endmodule

FILE: dv/tb_backlight_idle_dim_controller_unit.sv
// Testbench for backlight_idle_dim_controller_unit: directed rows and randomised
// phases, every result word scored against its row or an in-bench timer model.
// Depends on bidc_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb_backlight_idle_dim_controller_unit;
  import bidc_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned GAP_PCT         = 27;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned WORDS_PER_PHASE = 53;
  localparam int unsigned DRAIN_CYCLES    = 4;       // two-stage pipe plus margin
  localparam int unsigned MAX_REPORTS     = 10;
  localparam logic [1:0]  CMD_SPARE       = 2'd3;    // unused code, block must ignore it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd4;  // first index with no register
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [1:0]           cmd;
    logic [CFG_IDX_W-1:0] idx;
    logic [15:0]          val;     // delta_ms for a word, write data for a register
    bit                   typed;   // expected result given in the row itself
    result_t              want;
  } plan_row_t;

  // ---------------------------------------------------------------- DUT hookup
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata  = '0;
  logic [1:0]           s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [23:0]          m_axis_tdata;
  logic [1:0]           m_axis_tuser;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [15:0]          cfg_data_i    = '0;

  backlight_idle_dim_controller_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // ---------------------------------------------------------------- bench state
  logic              no_gaps = 1'b0;   // both sides run flat out while set
  int unsigned       mismatches = 0;
  int unsigned       cycle_cnt = 0;
  result_t           backlight_due[$]; // results owed by the block, oldest first
  plan_row_t         opening_rows[$];

  // Timer model: settings and state kept alongside the block.
  logic [TMO_W-1:0]  timeout_s;
  logic [PCT_W-1:0]  dim_pct;
  logic [PCT_W-1:0]  user_pct;
  logic [BL_W-1:0]   full_scale;
  logic [IDLE_W-1:0] idle_ms_q;
  logic              dim_q;
  logic              off_q;
  logic [BL_W-1:0]   held_bl_q;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- timer model
  // Only the low seven bits of a percent write count, then clamp to 100.
  function automatic logic [PCT_W-1:0] clamp_pct(input logic [15:0] data);
    return (data[PCT_W-1:0] > PCT_FULL) ? PCT_FULL : data[PCT_W-1:0];
  endfunction

  // percent * full scale / 100, rounded down
  function automatic logic [BL_W-1:0] pct_to_raw(input logic [PCT_W-1:0] pct);
    logic [31:0] prod;
    prod = 32'(pct) * 32'(full_scale);
    prod = prod / 32'(PCT_FULL);
    return prod[BL_W-1:0];
  endfunction

  function automatic void store_setting(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [15:0] data);
    case (idx)
      REG_TIMEOUT:  timeout_s  = data;
      REG_DIM_LVL:  dim_pct    = clamp_pct(data);
      REG_USER_LVL: user_pct   = clamp_pct(data);
      REG_MAX_BL:   full_scale = (data == '0) ? BL_DEFAULT : data;
      default: ;    // unknown index, nothing stored
    endcase
  endfunction

  function automatic result_t step_backlight(input logic [1:0] cmd,
                                             input logic [DELTA_W-1:0] delta);
    result_t         r;
    logic [31:0]     tmo_ms;
    logic [IDLE_W:0] sum;
    r = '0;
    r.notice = NOTICE_NONE;
    case (cmd)
      CMD_TICK: begin
        // a zero timeout freezes the timer, idle count included
        if (timeout_s != '0) begin
          tmo_ms = 32'(timeout_s) * MS_PER_S;
          sum = idle_ms_q + delta;
          idle_ms_q = sum[IDLE_W] ? '1 : sum[IDLE_W-1:0];
          // no dim stage when the timeout is shorter than the dim delay
          if (tmo_ms >= DIM_LEAD_MS && !dim_q && !off_q &&
              idle_ms_q >= tmo_ms - DIM_LEAD_MS) begin
            dim_q     = 1'b1;
            held_bl_q = pct_to_raw(dim_pct);
            r.apply   = 1'b1;
            r.notice  = NOTICE_DIM;
          end
          // may follow the dim in the same tick; final written value is then 0
          if (!off_q && idle_ms_q >= tmo_ms) begin
            off_q     = 1'b1;
            held_bl_q = '0;
            r.apply   = 1'b1;
          end
        end
      end
      CMD_WAKE: begin
        idle_ms_q = '0;
        if (dim_q || off_q) begin
          dim_q     = 1'b0;
          off_q     = 1'b0;
          held_bl_q = pct_to_raw(user_pct);
          r.apply   = 1'b1;
          r.notice  = NOTICE_WOKE;
        end
      end
      CMD_OFF: begin
        // idle count kept; writes 0 even when already off
        off_q     = 1'b1;
        dim_q     = 1'b0;
        held_bl_q = '0;
        r.apply   = 1'b1;
      end
      default: ;    // spare code: no change at all
    endcase
    r.value  = held_bl_q;
    r.dimmed = dim_q;
    r.off    = off_q;
    return r;
  endfunction

  // ---------------------------------------------------------------- opening rows
  function automatic void add_word(input logic [1:0] cmd, input logic [15:0] delta);
    plan_row_t row;
    row = '{kind: ROW_WORD, cmd: cmd, idx: '0, val: delta, typed: 1'b0, want: '0};
    opening_rows.push_back(row);
  endfunction

  function automatic void add_checked(input logic [1:0] cmd, input logic [15:0] delta,
                                      input logic apply, input logic [BL_W-1:0] value,
                                      input logic dimmed, input logic off,
                                      input notice_e notice);
    plan_row_t row;
    row = '{kind: ROW_WORD, cmd: cmd, idx: '0, val: delta, typed: 1'b1, want: '0};
    row.want.apply  = apply;
    row.want.value  = value;
    row.want.dimmed = dimmed;
    row.want.off    = off;
    row.want.notice = notice;
    opening_rows.push_back(row);
  endfunction

  function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    plan_row_t row;
    row = '{kind: ROW_REG, cmd: '0, idx: idx, val: data, typed: 1'b0, want: '0};
    opening_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------- drivers
  // Offer one input word, with random gaps ahead of it, and book its result.
  task automatic send_word(input logic [1:0] cmd, input logic [DELTA_W-1:0] delta,
                           input bit typed, input result_t typed_want);
    result_t predicted;
    cfg_valid_i <= 1'b0;
    while (!no_gaps && $urandom_range(99) < GAP_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= delta;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = step_backlight(cmd, delta);
    backlight_due.push_back(typed ? typed_want : predicted);
  endtask

  // Hold the sender off until every booked result has come back.
  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    cfg_valid_i   <= 1'b0;
    do @(posedge clk_i); while (backlight_due.size() != 0);
  endtask

  // Valid is left high so that writes can go back to back; send_word drops it.
  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    store_setting(idx, data);
  endtask

  // ---------------------------------------------------------------- result checker
  function automatic void log_mismatch(input string what, input result_t want,
                                       input result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] %s: exp a=%0d v=%0d d=%0d o=%0d n=%0d | got a=%0d v=%0d d=%0d o=%0d n=%0d p=%0h",
               $time, what, want.apply, want.value, want.dimmed, want.off, want.notice,
               got.apply, got.value, got.dimmed, got.off, got.notice, m_axis_tdata[23:19]);
  endfunction

  always @(posedge clk_i) begin : result_sink
    result_t got;
    result_t want;
    got.apply  = m_axis_tdata[0];
    got.value  = m_axis_tdata[16:1];
    got.dimmed = m_axis_tdata[17];
    got.off    = m_axis_tdata[18];
    got.notice = notice_e'(m_axis_tuser);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (backlight_due.size() == 0) begin
        log_mismatch("result word with none owed", '0, got);
      end else begin
        want = backlight_due.pop_front();
        if (got.apply !== want.apply || got.value !== want.value ||
            got.dimmed !== want.dimmed || got.off !== want.off ||
            got.notice !== want.notice || m_axis_tdata[23:19] !== '0)
          log_mismatch("result word mismatch", want, got);
      end
    end
    m_axis_tready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  initial begin : stimulus
    logic [15:0]          tmo;
    logic [15:0]          dim;
    logic [15:0]          usr;
    logic [15:0]          mx;
    logic [15:0]          junk;
    logic [CFG_IDX_W-1:0] junk_idx;
    logic [1:0]           cmd;
    logic [15:0]          delta;
    int unsigned          step_max;
    int unsigned          hold_at;
    int unsigned          r;

    // model starts from the block's reset values
    timeout_s  = 16'd60;
    dim_pct    = 7'd30;
    user_pct   = PCT_FULL;
    full_scale = BL_DEFAULT;
    idle_ms_q  = '0;
    dim_q      = 1'b0;
    off_q      = 1'b0;
    held_bl_q  = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset config: 60 s timeout, dim from 55 s, 30 % of 255 = 76, 100 % = 255.
    add_checked(CMD_TICK,  16'd0,     1'b0, 16'd0,   1'b0, 1'b0, NOTICE_NONE);
    add_checked(CMD_WAKE,  16'd0,     1'b0, 16'd0,   1'b0, 1'b0, NOTICE_NONE); // awake
    add_checked(CMD_SPARE, 16'd0,     1'b0, 16'd0,   1'b0, 1'b0, NOTICE_NONE);
    add_word   (CMD_TICK,  16'd54999);                                         // 1 ms short
    add_checked(CMD_TICK,  16'd1,     1'b1, 16'd76,  1'b1, 1'b0, NOTICE_DIM);
    add_checked(CMD_TICK,  16'd5000,  1'b1, 16'd0,   1'b1, 1'b1, NOTICE_NONE);
    add_checked(CMD_TICK,  16'hFFFF,  1'b0, 16'd0,   1'b1, 1'b1, NOTICE_NONE);
    add_checked(CMD_WAKE,  16'd0,     1'b1, 16'd255, 1'b0, 1'b0, NOTICE_WOKE);
    // dim and off in a single tick
    add_checked(CMD_TICK,  16'hFFFF,  1'b1, 16'd0,   1'b1, 1'b1, NOTICE_DIM);
    add_checked(CMD_OFF,   16'd0,     1'b1, 16'd0,   1'b0, 1'b1, NOTICE_NONE);
    add_checked(CMD_OFF,   16'hFFFF,  1'b1, 16'd0,   1'b0, 1'b1, NOTICE_NONE); // already off
    add_checked(CMD_WAKE,  16'd0,     1'b1, 16'd255, 1'b0, 1'b0, NOTICE_WOKE);
    // timer disabled
    add_reg    (REG_TIMEOUT, 16'd0);
    add_checked(CMD_TICK,  16'hFFFF,  1'b0, 16'd255, 1'b0, 1'b0, NOTICE_NONE);
    // 4 s is below the dim delay: straight to off
    add_reg    (REG_TIMEOUT, 16'd4);
    add_word   (CMD_TICK,  16'd3999);
    add_checked(CMD_TICK,  16'd1,     1'b1, 16'd0,   1'b0, 1'b1, NOTICE_NONE);
    add_checked(CMD_WAKE,  16'd0,     1'b1, 16'd255, 1'b0, 1'b0, NOTICE_WOKE);
    // clamped percents, full-scale max, timeout equal to the dim delay
    add_reg    (REG_DIM_LVL,  16'h00FF);   // 127 -> 100
    add_reg    (REG_USER_LVL, 16'hFF80);   // low bits 0
    add_reg    (REG_MAX_BL,   16'hFFFF);
    add_reg    (REG_TIMEOUT,  16'd5);
    add_checked(CMD_TICK,  16'd0,     1'b1, 16'hFFFF, 1'b1, 1'b0, NOTICE_DIM);
    add_word   (CMD_TICK,  16'd4999);
    add_checked(CMD_TICK,  16'd1,     1'b1, 16'd0,   1'b1, 1'b1, NOTICE_NONE);
    add_checked(CMD_WAKE,  16'd0,     1'b1, 16'd0,   1'b0, 1'b0, NOTICE_WOKE);
    // max 0 loads 255, 101 clamps, unknown indexes ignored, longest timeout
    add_reg    (REG_MAX_BL,   16'd0);
    add_reg    (REG_USER_LVL, 16'h0065);
    add_reg    (REG_DIM_LVL,  16'h0080);
    add_reg    (REG_UNUSED_LO, 16'hFFFF);
    add_reg    (REG_UNUSED_HI, 16'h0000);
    add_reg    (REG_TIMEOUT,  16'hFFFF);
    add_checked(CMD_WAKE,  16'd0,     1'b0, 16'd0,   1'b0, 1'b0, NOTICE_NONE);
    add_checked(CMD_SPARE, 16'hFFFF,  1'b0, 16'd0,   1'b0, 1'b0, NOTICE_NONE);
    add_word   (CMD_TICK,  16'hFFFF);

    foreach (opening_rows[i]) begin
      if (opening_rows[i].kind == ROW_REG) begin
        wait_all_results();
        write_setting(opening_rows[i].idx, opening_rows[i].val);
      end else begin
        send_word(opening_rows[i].cmd, opening_rows[i].val,
                  opening_rows[i].typed, opening_rows[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      // phase 1 runs with no gaps on either side
      no_gaps <= (p == 1);
      if (p == 0) begin
        // smallest non-zero timeout and max, user level clamped to full scale
        tmo = 16'd1;
        dim = 16'h0000;
        usr = 16'hFFFF;
        mx  = 16'd1;
      end else begin
        r = $urandom_range(9);
        if (r == 0)      tmo = '0;
        else if (r == 1) tmo = 16'($urandom());
        else             tmo = 16'($urandom_range(1, 20));
        if ($urandom_range(1) == 0) dim = 16'($urandom());
        else                        dim = 16'($urandom_range(0, 100));
        if ($urandom_range(1) == 0) usr = 16'($urandom());
        else                        usr = 16'($urandom_range(0, 100));
        if ($urandom_range(3) == 0) mx = 16'($urandom_range(1, 300));
        else                        mx = 16'($urandom());
      end
      junk_idx = CFG_IDX_W'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO));
      junk     = 16'($urandom());

      wait_all_results();
      write_setting(REG_TIMEOUT,  tmo);
      write_setting(REG_DIM_LVL,  dim);
      write_setting(REG_USER_LVL, usr);
      write_setting(REG_MAX_BL,   mx);
      write_setting(junk_idx,     junk);

      // tick sizes scaled so that dim and off come within a handful of ticks
      if (tmo == '0 || tmo > 16'd196) step_max = 65535;
      else                            step_max = tmo * MS_PER_S / 3;
      hold_at = $urandom_range(WORDS_PER_PHASE - 1);

      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        if (k == hold_at) wait_all_results();
        r = $urandom_range(99);
        if (r < 8)       cmd = CMD_WAKE;
        else if (r < 13) cmd = CMD_OFF;
        else if (r < 16) cmd = CMD_SPARE;
        else             cmd = CMD_TICK;
        r = $urandom_range(9);
        if (r == 0)      delta = '0;
        else if (r == 1) delta = '1;
        else if (r == 2) delta = 16'($urandom());
        else             delta = 16'($urandom_range(step_max));
        send_word(cmd, delta, 1'b0, '0);
      end
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/bidc_pkg.sv
rtl/bidc_step.sv
rtl/backlight_idle_dim_controller_unit.sv
dv/tb_backlight_idle_dim_controller_unit.sv
